// ===== rtl/lscf_pkg.sv =====
// Shared types, constants and helper functions for the line sensor centroid filter.
package lscf_pkg;

    // Defaults for the top-level parameters
    localparam int SENSOR_COUNT_DEF = 32;
    localparam int MAX_SEGMENTS_DEF = 4;

    // Fixed field and state widths
    localparam int SAMPLE_BITS = 12;
    localparam int IDX_W       = 5;
    localparam int SUM_W       = 17;
    localparam int WSUM_W      = 22;
    localparam int CNT_W       = 5;
    localparam int LED_W       = 32;
    localparam int POS_W       = 16;
    localparam int Q_W         = 12;
    localparam int LC_W        = 4;
    localparam int OPOS_W      = 8;
    localparam int WGT_W       = 9;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_W        = 32;
    localparam int OUT_W       = 104;

    // Divider: dividend is the weighted sum times eight
    localparam int DIV_W  = WSUM_W + 3;
    localparam int STEP_W = $clog2(DIV_W);

    // Frame snapshots waiting for evaluation
    localparam int QUEUE_DEPTH = 2;

    localparam logic [POS_W-1:0] POS_RESET      = 16'd31488;
    localparam logic [LC_W-1:0]  LINES_TOO_MANY = 4'd10;
    localparam logic [CNT_W-1:0] CNT_MAX        = 5'd31;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 3'd0,
        CFG_LED_TH  = 3'd1,
        CFG_MEAS_TH = 3'd2,
        CFG_LIM0    = 3'd3,
        CFG_LIM1    = 3'd4,
        CFG_LIM3    = 3'd5,
        CFG_LIM4    = 3'd6,
        CFG_WEIGHT  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic                   mode_skill;
        logic [SAMPLE_BITS-1:0] led_th;
        logic [SAMPLE_BITS-1:0] meas_th;
        logic [SUM_W-1:0]       lim0;
        logic [SUM_W-1:0]       lim1;
        logic [SUM_W-1:0]       lim3;
        logic [SUM_W-1:0]       lim4;
        logic [WGT_W-1:0]       weight;
    } cfg_t;

    // Evaluation sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SCAN,
        ST_DIV,
        ST_EMA,
        ST_DONE
    } back_state_t;

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic logic [WSUM_W-1:0] sat_wsum(input logic [WSUM_W-1:0] a,
                                                   input logic [SUM_W-1:0]  b);
        logic [WSUM_W:0] s;
        s = {1'b0, a} + (WSUM_W+1)'(b);
        return s[WSUM_W] ? {WSUM_W{1'b1}} : s[WSUM_W-1:0];
    endfunction

    // Weight of the new value, clamped to 256
    function automatic logic [WGT_W-1:0] eff_weight(input logic [WGT_W-1:0] w);
        return (w > 9'd256) ? 9'd256 : w;
    endfunction

    // Filtered count to line count
    function automatic logic [LC_W-1:0] count_decode(input logic [Q_W-1:0] q,
                                                     input logic         skill);
        logic [LC_W-1:0] r;
        if (q < 12'd128)       r = 4'd0;
        else if (skill && q < 12'd384) r = 4'd1;
        else if (skill && q < 12'd640) r = 4'd2;
        else if (!skill && q < 12'd512) r = 4'd1;
        else if (q < 12'd896)  r = 4'd3;
        else if (q < 12'd1152) r = 4'd4;
        else                   r = LINES_TOO_MANY;
        return r;
    endfunction

    // Q8 position to rounded integer
    function automatic logic [OPOS_W-1:0] round_pos(input logic [POS_W-1:0] p);
        logic [POS_W:0] s;
        s = {1'b0, p} + 17'd128;
        return s[POS_W-1:8];
    endfunction

endpackage

// ===== rtl/line_sensor_centroid_filter.sv =====
// Top level of the line sensor centroid filter: config registers, front, queue, back.
//
// Usage:
//   s_* carries one front/back sample pair per transfer; s_tlast marks the last
//   pair of a frame. m_* carries one result per frame: both LED words, the
//   filtered line count and four filtered positions. cfg_we/cfg_index/cfg_data
//   write the configuration registers; the user must write them only while
//   the block is idle, which the block itself does not enforce.
// Throughput and evaluation:
//   A pair is taken every cycle while the snapshot queue has room. At frame
//   end the front pushes a snapshot into a two-entry queue. The back evaluates
//   one snapshot at a time: it takes the count, then scans each slot; a slot
//   with data runs the 25-step serial divider and the filter update. Last it
//   loads the output register.
// Reset:
//   All filters, LED words and sums return to their reset values; positions
//   read 123 and the count 0.
// Stall:
//   A held result stalls the back; the queue then fills and s_tready drops.
module line_sensor_centroid_filter
    import lscf_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // sensor_index, front_sample, back_sample, pad
    input  logic                  s_tlast,   // frame_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // front_led_bits, back_led_bits, line_count,
                                             // position_first .. position_fourth, pad
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOTS  = (MAX_SEGMENTS < 2) ? 2 : MAX_SEGMENTS;
    localparam int SNAP_W = 1 + 2*LED_W + SLOTS*(SUM_W+WSUM_W) + SUM_W + CNT_W;

    cfg_t              cfg_reg, cfg_next;
    logic              accept, push, pop, full, empty;
    logic [SNAP_W-1:0] snap, q_data;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:    cfg_next.mode_skill = cfg_data[0];
                CFG_LED_TH:  cfg_next.led_th     = cfg_data[SAMPLE_BITS-1:0];
                CFG_MEAS_TH: cfg_next.meas_th    = cfg_data[SAMPLE_BITS-1:0];
                CFG_LIM0:    cfg_next.lim0       = cfg_data;
                CFG_LIM1:    cfg_next.lim1       = cfg_data;
                CFG_LIM3:    cfg_next.lim3       = cfg_data;
                CFG_LIM4:    cfg_next.lim4       = cfg_data;
                CFG_WEIGHT:  cfg_next.weight     = cfg_data[WGT_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_skill <= 1'b0;
            cfg_reg.led_th     <= 12'd1500;
            cfg_reg.meas_th    <= 12'd1500;
            cfg_reg.lim0       <= 17'd1000;
            cfg_reg.lim1       <= 17'd15000;
            cfg_reg.lim3       <= 17'd40000;
            cfg_reg.lim4       <= 17'd55000;
            cfg_reg.weight     <= 9'd102;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    lscf_front #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .accept (accept),
        .idx    (s_tdata[4:0]),
        .fv     (s_tdata[16:5]),
        .bv     (s_tdata[28:17]),
        .last   (s_tlast),
        .push   (push),
        .snap   (snap)
    );

    lscf_fifo #(
        .WIDTH (SNAP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (snap),
        .pop       (pop),
        .pop_data  (q_data),
        .full      (full),
        .empty     (empty)
    );

    lscf_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (empty),
        .q_data   (q_data),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/lscf_fifo.sv =====
// Short register queue of frame snapshots between front and back.
module lscf_fifo
    import lscf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_QW-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_QW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/lscf_front.sv =====
// Front part: LED bitmaps and per-frame accumulation, one sample pair per transfer.
module lscf_front
    import lscf_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   accept,
    input  logic [IDX_W-1:0]       idx,
    input  logic [SAMPLE_BITS-1:0] fv,
    input  logic [SAMPLE_BITS-1:0] bv,
    input  logic                   last,
    output logic                   push,
    output logic [1+2*LED_W+((MAX_SEGMENTS < 2) ? 2 : MAX_SEGMENTS)*(SUM_W+WSUM_W)
                  +SUM_W+CNT_W-1:0] snap
);

    localparam int SLOTS  = (MAX_SEGMENTS < 2) ? 2 : MAX_SEGMENTS;
    localparam int SLOT_W = $clog2(SLOTS);

    logic [LED_W-1:0]             fled_reg, fled_next, bled_reg, bled_next;
    logic [SLOTS-1:0][SUM_W-1:0]  sums_reg, sums_next;
    logic [SLOTS-1:0][WSUM_W-1:0] wsums_reg, wsums_next;
    logic [SUM_W-1:0]             total_reg, total_next;
    logic [CNT_W-1:0]             segnum_reg, segnum_next;
    logic [CNT_W-1:0]             raw_reg, raw_next;
    logic                         inside_reg, inside_next;
    logic                         in_range, sel_ok, f_meas, b_meas;
    logic [SLOT_W-1:0]            sel;
    logic [SUM_W-1:0]             fprod, bprod;

    assign in_range = (32'(idx) < SENSOR_COUNT);
    assign sel_ok   = (32'(segnum_reg) < MAX_SEGMENTS);
    assign sel      = segnum_reg[SLOT_W-1:0];
    assign f_meas   = (fv > cfg.meas_th);
    assign b_meas   = (bv > cfg.meas_th);
    assign fprod    = SUM_W'(fv) * SUM_W'(idx);
    assign bprod    = SUM_W'(bv) * SUM_W'(idx);
    assign push     = accept && last;

    // Per-pair update, snapshot and clear at frame end
    always_comb
    begin
        fled_next   = fled_reg;
        bled_next   = bled_reg;
        sums_next   = sums_reg;
        wsums_next  = wsums_reg;
        total_next  = total_reg;
        segnum_next = segnum_reg;
        raw_next    = raw_reg;
        inside_next = inside_reg;
        if (accept && in_range)
        begin
            fled_next[{idx[4:3], ~idx[2:0]}] = (fv > cfg.led_th);
            bled_next[{~idx[4:3], idx[2:0]}] = (bv > cfg.led_th);
            if (!cfg.mode_skill)
            begin
                if (f_meas)
                begin
                    sums_next[0]  = sat_sum(sums_reg[0], SUM_W'(fv));
                    wsums_next[0] = sat_wsum(wsums_reg[0], fprod);
                end
                if (b_meas)
                begin
                    sums_next[1]  = sat_sum(sums_reg[1], SUM_W'(bv));
                    wsums_next[1] = sat_wsum(wsums_reg[1], bprod);
                end
            end
            else if (f_meas)
            begin
                total_next = sat_sum(total_reg, SUM_W'(fv));
                for (int k = 0; k < SLOTS; k++)
                begin
                    if (sel_ok && sel == SLOT_W'(k))
                    begin
                        sums_next[k]  = sat_sum(sums_reg[k], SUM_W'(fv));
                        wsums_next[k] = sat_wsum(wsums_reg[k], fprod);
                    end
                end
                if (!inside_reg && raw_reg != CNT_MAX)
                begin
                    raw_next = raw_reg + 1'b1;
                end
                inside_next = 1'b1;
            end
            else if (inside_reg)
            begin
                if (segnum_reg != CNT_MAX)
                begin
                    segnum_next = segnum_reg + 1'b1;
                end
                inside_next = 1'b0;
            end
        end
        snap = {raw_next, total_next, wsums_next, sums_next, bled_next, fled_next,
                cfg.mode_skill};
        if (push)
        begin
            sums_next   = '0;
            wsums_next  = '0;
            total_next  = '0;
            segnum_next = '0;
            raw_next    = '0;
            inside_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fled_reg   <= '0;
            bled_reg   <= '0;
            sums_reg   <= '0;
            wsums_reg  <= '0;
            total_reg  <= '0;
            segnum_reg <= '0;
            raw_reg    <= '0;
            inside_reg <= 1'b0;
        end
        else
        begin
            fled_reg   <= fled_next;
            bled_reg   <= bled_next;
            sums_reg   <= sums_next;
            wsums_reg  <= wsums_next;
            total_reg  <= total_next;
            segnum_reg <= segnum_next;
            raw_reg    <= raw_next;
            inside_reg <= inside_next;
        end
    end

endmodule

// ===== rtl/lscf_back.sv =====
// Back part: per-frame evaluation, serial centroid divider, EMA filters, output register.
module lscf_back
    import lscf_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             q_empty,
    input  logic [1+2*LED_W+((MAX_SEGMENTS < 2) ? 2 : MAX_SEGMENTS)*(SUM_W+WSUM_W)
                  +SUM_W+CNT_W-1:0] q_data,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata   // front_led_bits, back_led_bits, line_count,
                                       // position_first .. position_fourth, zero pad
);

    localparam int SLOTS  = (MAX_SEGMENTS < 2) ? 2 : MAX_SEGMENTS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int SNAP_W = 1 + 2*LED_W + SLOTS*(SUM_W+WSUM_W) + SUM_W + CNT_W;

    back_state_t state_reg, state_next;

    logic [SNAP_W-1:0]            snap_reg, snap_next;
    logic                         s_mode;
    logic [LED_W-1:0]             s_fled, s_bled;
    logic [SLOTS-1:0][SUM_W-1:0]  s_sums;
    logic [SLOTS-1:0][WSUM_W-1:0] s_wsums;
    logic [SUM_W-1:0]             s_total;
    logic [CNT_W-1:0]             s_raw;

    logic [Q_W-1:0]    q_reg, q_next;
    logic [LC_W-1:0]   prev_reg, prev_next, cnt_reg, cnt_next;
    logic              reload_reg, reload_next;
    logic [SLOT_W-1:0] k_reg, k_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dd_reg, dd_next;
    logic [SLOTS-1:0][POS_W-1:0] pos_reg, pos_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  out_reg, out_next;

    logic [WGT_W-1:0]  w, inv;
    logic [LC_W-1:0]   n, dec;
    logic [Q_W-1:0]    q_new;
    logic [SUM_W:0]    rem_sh;
    logic [OPOS_W-1:0] c;
    logic [OPOS_W-1:0] opos [4];
    logic              k_last, out_free, slot_has;

    assign {s_raw, s_total, s_wsums, s_sums, s_bled, s_fled, s_mode} = snap_reg;

    assign w        = eff_weight(cfg.weight);
    assign inv      = 9'd256 - w;
    assign k_last   = (k_reg == SLOT_W'(SLOTS - 1));
    assign out_free = !m_tvalid_reg || m_tready;
    assign slot_has = (s_sums[k_reg] != '0);
    assign rem_sh   = {rem_reg, dd_reg[DIV_W-1]};
    assign c        = (dd_reg > DIV_W'(255)) ? 8'd255 : dd_reg[7:0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // Raw count of this frame, its filtered value and the decoded line count
    always_comb
    begin
        if (!s_mode)
        begin
            if (s_sums[0] < cfg.lim0)      n = 4'd0;
            else if (s_sums[0] < cfg.lim1) n = 4'd1;
            else if (s_sums[0] < cfg.lim3) n = 4'd3;
            else if (s_sums[0] < cfg.lim4) n = 4'd4;
            else                           n = LINES_TOO_MANY;
        end
        else
        begin
            if (s_total < cfg.lim0)                   n = 4'd0;
            else if (s_total > cfg.lim4)              n = LINES_TOO_MANY;
            else if (s_raw > CNT_W'(LINES_TOO_MANY))  n = LINES_TOO_MANY;
            else                                      n = s_raw[LC_W-1:0];
        end
        q_new = Q_W'(13'(w * n) + 13'((21'(inv) * 21'(q_reg)) >> 8));
        dec   = count_decode(q_new, s_mode);
    end

    // Rounded positions; slots that do not exist stay at the reset value
    for (genvar j = 0; j < 4; j++)
    begin : g_opos
        if (j < SLOTS)
        begin : g_slot
            assign opos[j] = round_pos(pos_reg[j]);
        end
        else
        begin : g_none
            assign opos[j] = round_pos(POS_RESET);
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (!q_empty) state_next = ST_COUNT;
            ST_COUNT: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (slot_has)    state_next = ST_DIV;
                else if (k_last) state_next = ST_DONE;
            end
            ST_DIV:   if (step_reg == STEP_W'(DIV_W - 1)) state_next = ST_EMA;
            ST_EMA:   state_next = k_last ? ST_DONE : ST_SCAN;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and datapath
    always_comb
    begin
        q_pop         = 1'b0;
        snap_next     = snap_reg;
        q_next        = q_reg;
        prev_next     = prev_reg;
        cnt_next      = cnt_reg;
        reload_next   = reload_reg;
        k_next        = k_reg;
        step_next     = step_reg;
        rem_next      = rem_reg;
        dd_next       = dd_reg;
        pos_next      = pos_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_next      = out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    snap_next = q_data;
                end
            end
            ST_COUNT:
            begin
                q_next      = q_new;
                cnt_next    = dec;
                reload_next = s_mode && (dec != prev_reg);
                if (s_mode)
                begin
                    prev_next = dec;
                end
                k_next = '0;
            end
            ST_SCAN:
            begin
                rem_next  = '0;
                dd_next   = {s_wsums[k_reg], 3'b000};
                step_next = '0;
                if (!slot_has && !k_last)
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                // one restoring step per cycle, quotient shifts into dd
                if (rem_sh >= {1'b0, s_sums[k_reg]})
                begin
                    rem_next = SUM_W'(rem_sh - {1'b0, s_sums[k_reg]});
                    dd_next  = {dd_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[SUM_W-1:0];
                    dd_next  = {dd_reg[DIV_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
            end
            ST_EMA:
            begin
                if (reload_reg)
                begin
                    pos_next[k_reg] = {c, 8'd0};
                end
                else
                begin
                    pos_next[k_reg] = POS_W'(17'(w * c)
                                      + 17'((25'(inv) * 25'(pos_reg[k_reg])) >> 8));
                end
                if (!k_last)
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    out_next = {4'd0, opos[3], opos[2], opos[1], opos[0], cnt_reg,
                                s_bled, s_fled};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            q_reg        <= '0;
            prev_reg     <= '0;
            pos_reg      <= {SLOTS{POS_RESET}};
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            q_reg        <= q_next;
            prev_reg     <= prev_next;
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        snap_reg   <= snap_next;
        cnt_reg    <= cnt_next;
        reload_reg <= reload_next;
        k_reg      <= k_next;
        step_reg   <= step_next;
        rem_reg    <= rem_next;
        dd_reg     <= dd_next;
        out_reg    <= out_next;
    end

`ifndef SYNTH
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> s_sums[k_reg] != '0)
        else $error("divider running on an empty slot");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !m_tvalid_reg) |=> m_tvalid_reg)
        else $error("finished frame not loaded into output register");

    a_count_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (out_reg[67:64] == 4'd0 || out_reg[67:64] == 4'd1
            || out_reg[67:64] == 4'd2 || out_reg[67:64] == 4'd3
            || out_reg[67:64] == 4'd4 || out_reg[67:64] == LINES_TOO_MANY))
        else $error("line count outside its code set");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE && !q_empty))
        else $error("snapshot taken while busy");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the line sensor centroid filter.
module testbench;
    import lscf_pkg::*;

    // Scoreboard: predicts frame results and checks them in order
    class frame_scoreboard;
        bit        mode;
        bit [11:0] led_th, meas_th;
        bit [16:0] lim0, lim1, lim3, lim4;
        bit [8:0]  wgt;
        bit [31:0] fled, bled;
        bit [16:0] ssum [4];
        bit [21:0] wsum [4];
        bit [16:0] tsum;
        int        seg_no, raw_cnt;
        bit        in_line;
        bit [15:0] pos [4];
        bit [11:0] qcnt;
        bit [3:0]  prev_cnt;
        bit [OUT_W-1:0] expected_frames [$];
        int        mismatches, frames_seen;

        function void reset_state();
            mode = 0; led_th = 1500; meas_th = 1500;
            lim0 = 1000; lim1 = 15000; lim3 = 40000; lim4 = 55000; wgt = 102;
            fled = 0; bled = 0; qcnt = 0; prev_cnt = 0;
            for (int k = 0; k < 4; k++) pos[k] = POS_RESET;
            clear_frame();
        endfunction

        function void clear_frame();
            for (int k = 0; k < 4; k++) begin ssum[k] = 0; wsum[k] = 0; end
            tsum = 0; seg_no = 0; raw_cnt = 0; in_line = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, bit [16:0] v);
            case (idx)
                CFG_MODE:    mode = v[0];
                CFG_LED_TH:  led_th = v[11:0];
                CFG_MEAS_TH: meas_th = v[11:0];
                CFG_LIM0:    lim0 = v;
                CFG_LIM1:    lim1 = v;
                CFG_LIM3:    lim3 = v;
                CFG_LIM4:    lim4 = v;
                CFG_WEIGHT:  wgt = v[8:0];
            endcase
        endfunction

        function void accumulate(int k, int v, int idx);
            int s, w;
            s = ssum[k] + v;
            w = wsum[k] + v * idx;
            ssum[k] = (s > 131071) ? 131071 : s;
            wsum[k] = (w > 4194303) ? 4194303 : w;
        endfunction

        function int eff_w();
            return (wgt > 256) ? 256 : wgt;
        endfunction

        function int centroid_of(int k);
            longint c;
            c = (longint'(wsum[k]) * 8) / ssum[k];
            return (c > 255) ? 255 : int'(c);
        endfunction

        function void smooth_pos(int k, int c);
            pos[k] = 16'((eff_w() * c * 256 + (256 - eff_w()) * pos[k]) >> 8);
        endfunction

        function void smooth_count(int n);
            qcnt = 12'((eff_w() * n * 256 + (256 - eff_w()) * qcnt) >> 8);
        endfunction

        // Note one accepted sample pair
        function void note_pair(bit [4:0] idx, bit [11:0] fv, bit [11:0] bv, bit last);
            int fb, bb, n, lc, c;
            fb = (idx / 8) * 8 + 7 - idx % 8;
            bb = (3 - idx / 8) * 8 + idx % 8;
            fled[fb] = (fv > led_th);
            bled[bb] = (bv > led_th);
            if (!mode) begin
                if (fv > meas_th) accumulate(0, fv, idx);
                if (bv > meas_th) accumulate(1, bv, idx);
            end else if (fv > meas_th) begin
                tsum = (tsum + fv > 131071) ? 17'd131071 : 17'(tsum + fv);
                if (seg_no < 4) accumulate(seg_no, fv, idx);
                if (!in_line && raw_cnt < 31) raw_cnt++;
                in_line = 1;
            end else if (in_line) begin
                if (seg_no < 31) seg_no++;
                in_line = 0;
            end
            if (!last) return;
            if (!mode) begin
                for (int k = 0; k < 2; k++)
                    if (ssum[k] > 0) smooth_pos(k, centroid_of(k));
                if (ssum[0] < lim0) n = 0;
                else if (ssum[0] < lim1) n = 1;
                else if (ssum[0] < lim3) n = 3;
                else if (ssum[0] < lim4) n = 4;
                else n = 10;
                smooth_count(n);
                if (qcnt < 128) lc = 0;
                else if (qcnt < 512) lc = 1;
                else if (qcnt < 896) lc = 3;
                else if (qcnt < 1152) lc = 4;
                else lc = 10;
            end else begin
                n = raw_cnt;
                if (tsum < lim0) n = 0;
                else if (tsum > lim4) n = 10;
                if (n > 10) n = 10;
                smooth_count(n);
                if (qcnt < 128) lc = 0;
                else if (qcnt < 384) lc = 1;
                else if (qcnt < 640) lc = 2;
                else if (qcnt < 896) lc = 3;
                else if (qcnt < 1152) lc = 4;
                else lc = 10;
                for (int k = 0; k < 4; k++)
                    if (ssum[k] > 0) begin
                        c = centroid_of(k);
                        if (lc != prev_cnt) pos[k] = 16'(c << 8);
                        else smooth_pos(k, c);
                    end
                prev_cnt = 4'(lc);
            end
            expected_frames.push_back({round8(3), round8(2), round8(1), round8(0),
                                       4'(lc), bled, fled});
            clear_frame();
        endfunction

        function bit [7:0] round8(int k);
            return 8'((pos[k] + 128) >> 8);
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_frame(bit [OUT_W-1:0] got);
            bit [OUT_W-1:0] exp_v;
            frames_seen++;
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_v = expected_frames.pop_front();
            if (got[31:0] != exp_v[31:0] || got[63:32] != exp_v[63:32] ||
                got[67:64] != exp_v[67:64] || got[75:68] != exp_v[75:68] ||
                got[83:76] != exp_v[83:76] || got[91:84] != exp_v[91:84] ||
                got[99:92] != exp_v[99:92]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch frame %0d: exp fl=%h bl=%h lc=%0d p=%0d,%0d,%0d,%0d",
                             frames_seen, exp_v[31:0], exp_v[63:32], exp_v[67:64],
                             exp_v[75:68], exp_v[83:76], exp_v[91:84], exp_v[99:92],
                             "\n    got fl=%h bl=%h lc=%0d p=%0d,%0d,%0d,%0d",
                             got[31:0], got[63:32], got[67:64],
                             got[75:68], got[83:76], got[91:84], got[99:92]);
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic s_tvalid, s_tready, s_tlast;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid, m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    frame_scoreboard sb;
    int  cycles;
    int  pairs_sent;
    bit  hold_off;
    localparam int CYCLE_LIMIT = 600000;

    line_sensor_centroid_filter u_top (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Cycle counter with timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Result side: random stalls plus one long hold-off
    initial
    begin
        int gap;
        m_tready = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) m_tready = 0;
            else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                if (cycles % 4000 < 1000) gap = 0;
                m_tready = 0;
                repeat (gap) @(negedge clk);
                m_tready = !hold_off;
                @(posedge clk);
                while (!(m_tvalid && m_tready)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready) sb.check_frame(m_tdata);

    // One sample pair transfer
    task automatic send_pair(bit [4:0] idx, bit [11:0] fv, bit [11:0] bv, bit last,
                             bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        if (!no_gap && $urandom_range(0, 2) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {3'b000, bv, fv, idx};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_pair(idx, fv, bv, last);
        pairs_sent++;
        @(negedge clk);
    endtask

    task automatic go_idle();
        s_tvalid <= 0;
        while (sb.expected_frames.size() != 0) @(negedge clk);
        repeat (130) @(negedge clk);
    endtask

    task automatic write_cfg(cfg_idx_t idx, bit [16:0] v);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        @(negedge clk);
        cfg_we <= 0;
        sb.write_reg(idx, v);
        @(negedge clk);
    endtask

    // Frame of random content shaped around the measure threshold
    task automatic random_frame(int len, bit no_gap = 0);
        bit [11:0] fv, bv;
        int style;
        style = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            case (style)
                0: begin fv = $urandom; bv = $urandom; end
                1: begin
                    fv = ((i / 3) % 2) ? 12'($urandom_range(2500, 4095))
                                       : 12'($urandom_range(0, 1000));
                    bv = $urandom_range(1200, 4095);
                end
                2: begin
                    fv = ($urandom_range(0, 4) == 0) ? 12'hFFF : 12'($urandom_range(0, 1600));
                    bv = $urandom_range(0, 1600);
                end
                default: begin
                    fv = ($urandom_range(0, 1)) ? 12'($urandom_range(1501, 4095)) : 12'd0;
                    bv = $urandom;
                end
            endcase
            send_pair((len == 32) ? 5'(i) : 5'($urandom), fv, bv, i == len - 1, no_gap);
        end
    endtask

    task automatic random_cfg(bit skill);
        write_cfg(CFG_MODE, skill);
        write_cfg(CFG_LED_TH, $urandom_range(0, 4095));
        write_cfg(CFG_MEAS_TH, $urandom_range(800, 3000));
        write_cfg(CFG_LIM0, $urandom_range(0, 5000));
        write_cfg(CFG_LIM1, $urandom_range(5000, 30000));
        write_cfg(CFG_LIM3, $urandom_range(30000, 50000));
        write_cfg(CFG_LIM4, $urandom_range(50000, 80000));
        write_cfg(CFG_WEIGHT, ($urandom_range(0, 5) == 0) ? 17'd511 : 17'($urandom_range(0, 256)));
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        rst_n = 0; s_tvalid = 0; s_tdata = 0; s_tlast = 0;
        cfg_we = 0; cfg_index = 0; cfg_data = 0; hold_off = 0;
        repeat (2) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: extremes, out-of-order index, frame end only, full frame
        send_pair(0, 12'hFFF, 12'h000, 0);
        send_pair(31, 12'h000, 12'hFFF, 0);
        send_pair(5'h1F, 12'hFFF, 12'hFFF, 1);
        send_pair(7, 12'd1500, 12'd1501, 1);
        random_frame(32);
        go_idle();
        // Extreme settings: saturating sums, weight above 256, zero measure threshold, maximum LED threshold
        write_cfg(CFG_MEAS_TH, 0);
        write_cfg(CFG_LED_TH, 4095);
        write_cfg(CFG_WEIGHT, 511);
        write_cfg(CFG_LIM4, 131040);
        for (int i = 0; i < 40; i++) send_pair(31, 12'hFFF, 12'hFFF, i == 39, 1);
        go_idle();
        // Skill mode with many short runs
        write_cfg(CFG_MODE, 1);
        write_cfg(CFG_MEAS_TH, 2000);
        write_cfg(CFG_WEIGHT, 0);
        for (int i = 0; i < 32; i++) send_pair(5'(i), (i % 2) ? 12'd0 : 12'hFFF, 12'd9, i == 31, 1);
        go_idle();

        // Random phases
        while (pairs_sent < 1730) begin
            random_cfg($urandom_range(0, 1));
            for (int f = 0; f < 8; f++)
                random_frame(($urandom_range(0, 5) == 0) ? $urandom_range(1, 45) : 32);
            if (pairs_sent > 900 && pairs_sent < 1300 && !hold_off) begin
                // Result side held off while frames keep coming
                fork
                    begin hold_off = 1; repeat (3000) @(posedge clk); hold_off = 0; end
                    for (int f = 0; f < 6; f++) random_frame(32, 1);
                join
            end
            go_idle();
        end
        $display("frames checked: %0d, pairs sent: %0d, both modes and extreme settings",
                 sb.frames_seen, pairs_sent);
        if (sb.mismatches == 0 && sb.expected_frames.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
